### src/sliding_window_receiver_assert.svh
// Assertion macros for the sliding window receiver RTL.
`ifndef SLIDING_WINDOW_RECEIVER_ASSERT_SVH
`define SLIDING_WINDOW_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define SWR_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swr assertion failed");

// Next-cycle implication.
`define SWR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swr assertion failed");

`endif

### src/swr_pkg.sv
// Types and constants of the sliding window receiver.
package swr_pkg;

    localparam int MAX_WINDOW  = 32;
    localparam int MAP_DEPTH   = 2 * MAX_WINDOW;
    localparam int MAP_AW      = 6;
    localparam int SEQ_W       = 6;
    localparam int WIN_W       = 6;
    localparam int SPACE_W     = SEQ_W + 1;
    localparam int MC_W        = 7;
    localparam int REM_W       = 8;
    localparam int MOD_STEPS   = 7;
    localparam int DIV_W       = SPACE_W + MOD_STEPS - 1;
    localparam int STEP_W      = 3;

    localparam logic [WIN_W-1:0] WSIZE_RESET = 6'd4;

    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_MLD,
        ST_MHS,
        ST_MLA,
        ST_WALK,
        ST_OUT
    } t_state;

endpackage

### src/sliding_window_receiver.sv
// Sliding window receiver: window check, received bitmap, in-order release, ack.
//
// Input channel i_valid/o_stall carries one request per item: i_opcode (frame or
// timeout) and i_seq. Output channel o_valid/i_stall returns exactly one result
// per request. The window size register is written through i_cfg_wr_en and
// i_cfg_wr_data; the user must write it only while no request is in progress, as the block does not enforce it.
// A request is held in the block until its result is taken; o_stall stays high
// meanwhile. A request without release passes through the read and evaluate
// states before its result shows, and the next request is taken only after
// that result is taken. A request that releases slots adds three remainder
// computations on the shared restoring compare-subtract unit, then clears each
// released slot in the bitmap memory (1 to 2*W slots) one at a time, since
// the bitmap has a single write port. One request is in flight at a time.
// After reset all 64 bitmap entries are cleared one entry per cycle,
// with o_stall high; the window size register returns to 4 and any open
// transfer is closed. While i_stall is high the result holds and no new
// request is taken.
`include "sliding_window_receiver_assert.svh"

module sliding_window_receiver (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [swr_pkg::WIN_W-1:0]    i_cfg_wr_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_opcode,
    input  logic [swr_pkg::SEQ_W-1:0]    i_seq,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_in_window,
    output logic                         o_ack_valid,
    output logic [swr_pkg::SEQ_W-1:0]    o_ack_seq,
    output logic [swr_pkg::SEQ_W-1:0]    o_release_first,
    output logic                         o_transfer_active
);
    import swr_pkg::*;

    // circular window test: s in (lo, hi]
    function automatic logic f_inside(logic [SEQ_W-1:0] s, logic [SEQ_W-1:0] lo,
                                      logic [SEQ_W-1:0] hi);
        logic res;
        if (lo < hi) res = (s <= hi) && (s > lo);
        else         res = (s <= hi) || (s > lo);
        return res;
    endfunction

    // newer of a and b with respect to the window (lo, hi]
    function automatic logic [SEQ_W-1:0] f_newer(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                                 logic [SEQ_W-1:0] hi, logic [SEQ_W-1:0] lo);
        logic [SEQ_W-1:0] big;
        logic [SEQ_W-1:0] sml;
        logic [SEQ_W-1:0] res;
        big = (a > b) ? a : b;
        sml = (a > b) ? b : a;
        if (lo < hi)                                        res = big;
        else if ((a >= lo && b >= lo) || (a <= hi && b <= hi)) res = big;
        else                                                res = sml;
        return res;
    endfunction

    // control state
    t_state              r_state, n_state;
    logic                r_active, n_active;
    logic [SEQ_W-1:0]    r_ld, n_ld;
    logic [SEQ_W-1:0]    r_la, n_la;
    logic [SEQ_W-1:0]    r_hs, n_hs;
    logic [MC_W-1:0]     r_mc, n_mc;
    logic [WIN_W-1:0]    r_wsize;
    logic [MAP_AW-1:0]   r_i, n_i;

    // datapath
    logic                r_opcode, n_opcode;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [DIV_W-1:0]    r_div, n_div;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [SEQ_W-1:0]    r_a, n_a;
    logic [SEQ_W-1:0]    r_b, n_b;
    logic [MAP_AW-1:0]   r_n, n_n;
    logic                r_in_window, n_in_window;
    logic                r_ack_valid, n_ack_valid;
    logic [SEQ_W-1:0]    r_ack_seq, n_ack_seq;
    logic [SEQ_W-1:0]    r_rel_first, n_rel_first;

    // bitmap memory
    logic                r_map [MAP_DEPTH];
    logic                r_rd;
    logic                mem_we;
    logic [MAP_AW-1:0]   mem_wa;
    logic                mem_wd;

    logic [WIN_W-1:0]    w_eff;
    logic [SPACE_W-1:0]  space;
    logic [SPACE_W-1:0]  space_m1;
    logic                seq_ok;
    logic [SEQ_W-1:0]    seq_newer;
    logic                mod_ge;
    logic [REM_W-1:0]    mod_next;
    logic [SPACE_W-1:0]  i_inc;
    logic [SPACE_W-1:0]  a_inc;
    logic [SEQ_W-1:0]    rel_start;
    logic                rel;

    always_comb begin
        if (r_wsize == '0)
            w_eff = WIN_W'(1);
        else if (r_wsize > WIN_W'(MAX_WINDOW))
            w_eff = WIN_W'(MAX_WINDOW);
        else
            w_eff = r_wsize;
    end

    assign space     = {w_eff, 1'b0};
    assign space_m1  = space - SPACE_W'(1);
    assign seq_ok    = {1'b0, r_seq} < space;
    assign seq_newer = f_newer(r_hs, r_seq, r_la, r_ld);

    // one restoring step of the shared remainder unit
    assign mod_ge   = {{(DIV_W-REM_W){1'b0}}, r_rem} >= r_div;
    assign mod_next = mod_ge ? (r_rem - r_div[REM_W-1:0]) : r_rem;

    assign i_inc     = {1'b0, r_i} + SPACE_W'(1);
    assign a_inc     = {1'b0, r_a} + SPACE_W'(1);
    assign rel_start = (a_inc == space) ? '0 : a_inc[SEQ_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_ld        = r_ld;
        n_la        = r_la;
        n_hs        = r_hs;
        n_mc        = r_mc;
        n_i         = r_i;
        n_opcode    = r_opcode;
        n_seq       = r_seq;
        n_rem       = r_rem;
        n_div       = r_div;
        n_step      = r_step;
        n_a         = r_a;
        n_b         = r_b;
        n_n         = r_n;
        n_in_window = r_in_window;
        n_ack_valid = r_ack_valid;
        n_ack_seq   = r_ack_seq;
        n_rel_first = r_rel_first;
        mem_we      = 1'b0;
        mem_wa      = r_i;
        mem_wd      = 1'b0;
        rel         = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_i == MAP_AW'(MAP_DEPTH - 1)) begin
                    n_i     = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_i = r_i + MAP_AW'(1);
                end
            end

            ST_IDLE: begin
                if (i_valid) begin
                    n_opcode = i_opcode;
                    n_seq    = i_seq;
                    n_state  = ST_READ;
                end
            end

            ST_READ: begin
                n_state = ST_EVAL;
            end

            ST_EVAL: begin
                n_state     = ST_OUT;
                n_in_window = 1'b0;
                n_ack_valid = 1'b0;
                n_ack_seq   = '0;
                n_rel_first = '0;
                mem_wa      = r_seq;
                mem_wd      = 1'b1;
                if (r_opcode == OP_TIMEOUT) begin
                    n_active = 1'b0;
                end else if (seq_ok) begin
                    if (!r_active) begin
                        // opening frame
                        n_active = 1'b1;
                        n_ld     = space_m1[SEQ_W-1:0];
                        n_la     = w_eff - WIN_W'(1);
                        n_hs     = r_seq;
                        n_mc     = {1'b0, r_seq};
                        if (r_seq < w_eff) begin
                            n_in_window = 1'b1;
                            mem_we      = 1'b1;
                            rel         = (r_seq == '0);
                        end
                    end else if (f_inside(r_seq, r_ld, r_la)) begin
                        n_in_window = 1'b1;
                        mem_we      = 1'b1;
                        if (seq_newer == r_hs) begin
                            // fills a gap, unless it is a duplicate
                            if (!r_rd)
                                n_mc = r_mc - MC_W'(1);
                        end else if (r_hs < r_seq) begin
                            n_mc = r_mc + {1'b0, r_seq} - {1'b0, r_hs} - MC_W'(1);
                        end else begin
                            n_mc = r_mc + space - {1'b0, r_hs} - MC_W'(1) + {1'b0, r_seq};
                        end
                        n_hs = seq_newer;
                        rel  = (n_mc == '0);
                    end
                end
                if (rel) begin
                    n_state = ST_MLD;
                    n_rem   = {2'b00, n_ld};
                    n_div   = {space, {(MOD_STEPS-1){1'b0}}};
                    n_step  = '0;
                end
            end

            ST_MLD: begin
                n_rem  = mod_next;
                n_div  = r_div >> 1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MOD_STEPS - 1)) begin
                    n_a     = mod_next[SEQ_W-1:0];
                    n_rem   = {2'b00, r_hs};
                    n_div   = {space, {(MOD_STEPS-1){1'b0}}};
                    n_step  = '0;
                    n_state = ST_MHS;
                end
            end

            ST_MHS: begin
                n_rem  = mod_next;
                n_div  = r_div >> 1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MOD_STEPS - 1)) begin
                    n_b     = mod_next[SEQ_W-1:0];
                    // slid upper edge, reduced in the next pass
                    n_rem   = {2'b00, r_la} + {1'b0, space} - {2'b00, r_a} + mod_next;
                    n_div   = {space, {(MOD_STEPS-1){1'b0}}};
                    n_step  = '0;
                    n_state = ST_MLA;
                end
            end

            ST_MLA: begin
                n_rem  = mod_next;
                n_div  = r_div >> 1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MOD_STEPS - 1)) begin
                    n_la        = mod_next[SEQ_W-1:0];
                    n_ld        = r_b;
                    n_i         = rel_start;
                    n_n         = '0;
                    n_rel_first = rel_start;
                    n_state     = ST_WALK;
                end
            end

            ST_WALK: begin
                mem_we = 1'b1;
                mem_wa = r_i;
                mem_wd = 1'b0;
                if (r_i == r_hs || r_n == space_m1[MAP_AW-1:0]) begin
                    n_ack_valid = 1'b1;
                    n_ack_seq   = r_hs;
                    n_i         = '0;
                    n_state     = ST_OUT;
                end else begin
                    n_i = (i_inc == space) ? '0 : i_inc[MAP_AW-1:0];
                    n_n = r_n + MAP_AW'(1);
                end
            end

            ST_OUT: begin
                if (!i_stall)
                    n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_active <= 1'b0;
            r_ld     <= '0;
            r_la     <= '0;
            r_hs     <= '0;
            r_mc     <= '0;
            r_wsize  <= WSIZE_RESET;
            r_i      <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_ld     <= n_ld;
            r_la     <= n_la;
            r_hs     <= n_hs;
            r_mc     <= n_mc;
            r_i      <= n_i;
            if (i_cfg_wr_en)
                r_wsize <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opcode    <= n_opcode;
        r_seq       <= n_seq;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_step      <= n_step;
        r_a         <= n_a;
        r_b         <= n_b;
        r_n         <= n_n;
        r_in_window <= n_in_window;
        r_ack_valid <= n_ack_valid;
        r_ack_seq   <= n_ack_seq;
        r_rel_first <= n_rel_first;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_map[mem_wa] <= mem_wd;
        r_rd <= r_map[r_seq];
    end

    assign o_stall           = (r_state != ST_IDLE);
    assign o_valid           = (r_state == ST_OUT);
    assign o_in_window       = r_in_window;
    assign o_ack_valid       = r_ack_valid;
    assign o_ack_seq         = r_ack_seq;
    assign o_release_first   = r_rel_first;
    assign o_transfer_active = r_active;

    `SWR_ASSERT_NOW(a_ack_needs_record, o_valid && o_ack_valid, o_in_window && r_active)
    `SWR_ASSERT_NOW(a_no_ack_zero_fields, o_valid && !o_ack_valid, (o_ack_seq == '0 && o_release_first == '0))
    `SWR_ASSERT_NOW(a_walk_in_space, (r_state == ST_WALK), (({1'b0, r_n} < space) && ({1'b0, r_i} < space)))
    `SWR_ASSERT_NEXT(a_accept_reads_map, r_state == ST_IDLE && i_valid, r_state == ST_READ)

endmodule

### sim/tb_sliding_window_receiver.sv
// Self-checking testbench for the sliding window receiver with a built-in predictor.
`timescale 1ns / 1ps

module tb_sliding_window_receiver;
    import swr_pkg::*;

    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 155;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTED    = 200;

    typedef struct packed {
        logic               in_window;
        logic               ack_valid;
        logic [SEQ_W-1:0]   ack_seq;
        logic [SEQ_W-1:0]   release_first;
        logic               transfer_active;
    } t_window_result;

    // Predicts one result per request and checks what the block returns.
    class swr_scoreboard;
        bit [WIN_W-1:0]   win_reg;
        bit               open;
        bit [SEQ_W-1:0]   ld;
        bit [SEQ_W-1:0]   la;
        bit [SEQ_W-1:0]   hs;
        bit [MC_W-1:0]    miss;
        bit               seen [MAP_DEPTH];
        t_window_result   expected_q [$];
        int               errors;
        int               requests;
        int               checked;
        int               in_window_cnt;
        int               timeouts;
        int               acks;
        int               settings;

        function new();
            win_reg = WSIZE_RESET;
            open = 1'b0;
            ld = '0;
            la = '0;
            hs = '0;
            miss = '0;
            foreach (seen[i]) seen[i] = 1'b0;
            settings = 1;
        endfunction

        function int eff_window();
            int w;
            w = int'(win_reg);
            if (w < 1) w = 1;
            if (w > MAX_WINDOW) w = MAX_WINDOW;
            return w;
        endfunction

        function void set_window(bit [WIN_W-1:0] v);
            win_reg = v;
            settings++;
        endfunction

        function bit in_range(int s, int lo, int hi);
            if (lo < hi) return s <= hi && s > lo;
            return s <= hi || s > lo;
        endfunction

        // newer of two numbers as seen from the circular window
        function int newer(int a, int b, int hi, int lo);
            int big;
            int tiny;
            big = a > b ? a : b;
            tiny = a > b ? b : a;
            if (lo < hi) return big;
            if ((a >= lo && b >= lo) || (a <= hi && b <= hi)) return big;
            return tiny;
        endfunction

        // in-order release from last delivered up to the newest number, sliding the window
        function void slide(int sp, inout t_window_result r);
            int start;
            int i;
            start = (int'(ld) + 1) % sp;
            i = start;
            for (int n = 0; n < sp; n++) begin
                seen[i % MAP_DEPTH] = 1'b0;
                if (i == int'(hs)) break;
                i = (i + 1) % sp;
            end
            la = SEQ_W'((int'(la) + sp - (int'(ld) % sp) + (int'(hs) % sp)) % sp);
            ld = SEQ_W'(int'(hs) % sp);
            r.ack_valid = 1'b1;
            r.ack_seq = hs;
            r.release_first = start[SEQ_W-1:0];
            acks++;
        endfunction

        function void note_request(logic op, logic [SEQ_W-1:0] seq);
            int w;
            int sp;
            int s;
            int m;
            t_window_result r;
            w = eff_window();
            sp = 2 * w;
            s = int'(seq);
            r = '0;
            requests++;
            if (op == OP_TIMEOUT) begin
                open = 1'b0;
                timeouts++;
            end else if (s < sp) begin
                if (!open) begin
                    open = 1'b1;
                    ld = SEQ_W'(sp - 1);
                    la = SEQ_W'(w - 1);
                    hs = SEQ_W'(s);
                    miss = MC_W'(s);
                    if (in_range(s, int'(ld), int'(la))) begin
                        r.in_window = 1'b1;
                        seen[s] = 1'b1;
                        if (miss == 0) slide(sp, r);
                    end
                end else if (in_range(s, int'(ld), int'(la))) begin
                    m = newer(int'(hs), s, int'(la), int'(ld));
                    r.in_window = 1'b1;
                    if (m == int'(hs)) begin
                        if (!seen[s]) miss = MC_W'(int'(miss) - 1);
                    end else if (int'(hs) < s) begin
                        miss = MC_W'(int'(miss) + s - int'(hs) - 1);
                    end else begin
                        miss = MC_W'(int'(miss) + sp - int'(hs) - 1 + s);
                    end
                    hs = SEQ_W'(m);
                    seen[s] = 1'b1;
                    if (miss == 0) slide(sp, r);
                end
            end
            if (r.in_window) in_window_cnt++;
            r.transfer_active = open;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
        endtask

        task check_result(t_window_result got);
            t_window_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with no request pending: %h", got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.in_window !== want.in_window)
                report($sformatf("result %0d in_window got %b want %b",
                                 checked, got.in_window, want.in_window));
            if (got.ack_valid !== want.ack_valid)
                report($sformatf("result %0d ack_valid got %b want %b",
                                 checked, got.ack_valid, want.ack_valid));
            if (got.ack_seq !== want.ack_seq)
                report($sformatf("result %0d ack_seq got %0d want %0d",
                                 checked, got.ack_seq, want.ack_seq));
            if (got.release_first !== want.release_first)
                report($sformatf("result %0d release_first got %0d want %0d",
                                 checked, got.release_first, want.release_first));
            if (got.transfer_active !== want.transfer_active)
                report($sformatf("result %0d transfer_active got %b want %b",
                                 checked, got.transfer_active, want.transfer_active));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [WIN_W-1:0]   i_cfg_wr_data;
    logic               i_valid;
    logic               o_stall;
    logic               i_opcode;
    logic [SEQ_W-1:0]   i_seq;
    logic               o_valid;
    logic               i_stall;
    logic               o_in_window;
    logic               o_ack_valid;
    logic [SEQ_W-1:0]   o_ack_seq;
    logic [SEQ_W-1:0]   o_release_first;
    logic               o_transfer_active;

    swr_scoreboard sb;
    bit sender_quiet;
    bit sink_quiet;
    bit hold_request;
    int items_sent;

    sliding_window_receiver dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_seq             (i_seq),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_in_window       (o_in_window),
        .o_ack_valid       (o_ack_valid),
        .o_ack_seq         (o_ack_seq),
        .o_release_first   (o_release_first),
        .o_transfer_active (o_transfer_active)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request channel: valid stays high across back-to-back requests
    task automatic send_item(input logic op, input logic [SEQ_W-1:0] seq);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_seq <= seq;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(op, seq);
        items_sent++;
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 7) == 0)
            send_item(OP_TIMEOUT, 6'($urandom_range(0, 63)));
        else
            send_item(OP_FRAME, 6'($urandom_range(0, 63)));
    endtask

    // one window's worth of frames, mostly shuffled, sometimes cut short or repeated
    task automatic send_window_batch();
        int w;
        int sp;
        int lo;
        int cnt;
        int k;
        int tmp;
        int slots [$];
        w = sb.eff_window();
        sp = 2 * w;
        lo = sb.open ? int'(sb.ld) : sp - 1;
        for (int j = 0; j < w; j++) slots.push_back((lo + 1 + j) % sp);
        if ($urandom_range(0, 3) != 0) begin
            for (int j = w - 1; j > 0; j--) begin
                k = $urandom_range(0, j);
                tmp = slots[j];
                slots[j] = slots[k];
                slots[k] = tmp;
            end
        end
        cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w) : w;
        for (int j = 0; j < cnt; j++) begin
            if ($urandom_range(0, 15) == 0) send_noise();
            send_item(OP_FRAME, 6'(slots[j]));
            if ($urandom_range(0, 9) == 0) send_item(OP_FRAME, 6'(slots[$urandom_range(0, j)]));
        end
    endtask

    // nothing in flight and every result back
    task automatic wait_idle();
        do @(posedge i_clk); while (sb.expected_q.size() != 0 || o_stall);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] v);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        sb.set_window(v);
        i_cfg_wr_en <= 1'b0;
    endtask

    // result channel
    initial begin
        int k;
        t_window_result got;
        i_stall <= 1'b0;
        wait (i_rst_n);
        forever begin
            k = sink_quiet ? 0 : $urandom_range(0, 9);
            if (hold_request) begin
                hold_request = 1'b0;
                k = LONG_HOLD;
            end
            if (k > 0) begin
                i_stall <= 1'b1;
                repeat (k) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
            got = {o_in_window, o_ack_valid, o_ack_seq, o_release_first, o_transfer_active};
            sb.check_result(got);
        end
    end

    // ends the run when no request moves on either channel for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int phase_end;
        logic [WIN_W-1:0] wsel;
        sb = new();
        sender_quiet = 1'b0;
        sink_quiet = 1'b0;
        hold_request = 1'b0;
        items_sent = 0;
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        i_valid <= 1'b0;
        i_opcode <= OP_FRAME;
        i_seq <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // window of 4 out of reset: sequence space 0..7
        send_item(OP_TIMEOUT, 6'd0);    // timeout with no transfer open
        send_item(OP_FRAME, 6'd63);     // beyond the sequence space, no transfer
        send_item(OP_FRAME, 6'd0);      // opens and releases at once
        send_item(OP_FRAME, 6'd2);
        send_item(OP_FRAME, 6'd1);      // fills the hole, releases 1..2
        send_item(OP_FRAME, 6'd2);      // already delivered
        send_item(OP_FRAME, 6'd4);
        send_item(OP_FRAME, 6'd4);      // repeat inside the window
        send_item(OP_FRAME, 6'd3);
        send_item(OP_FRAME, 6'd7);
        send_item(OP_FRAME, 6'd6);
        send_item(OP_FRAME, 6'd5);
        send_item(OP_FRAME, 6'd1);      // window wraps past the top of the space
        send_item(OP_FRAME, 6'd0);
        send_item(OP_TIMEOUT, 6'd0);
        send_item(OP_FRAME, 6'd5);      // opening frame above the first window
        send_item(OP_FRAME, 6'd9);      // beyond the space while open
        send_item(OP_TIMEOUT, 6'd63);
        i_valid <= 1'b0;

        // zero window is taken as one: space of two
        write_window(6'd0);
        send_item(OP_FRAME, 6'd1);
        send_item(OP_FRAME, 6'd0);
        send_item(OP_TIMEOUT, 6'd0);
        send_item(OP_FRAME, 6'd0);
        send_item(OP_FRAME, 6'd1);
        send_item(OP_FRAME, 6'd2);
        i_valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: wsel = 6'd63;
                1: wsel = 6'd32;
                2: wsel = 6'd1;
                3: wsel = 6'd0;
                default: wsel = 6'($urandom_range(0, 63));
            endcase
            write_window(wsel);
            sender_quiet = (p == 5 || p == 7);
            sink_quiet = (p == 5);
            if (p == 7) hold_request = 1'b1;
            if (p == 0) send_item(OP_FRAME, 6'd63);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) send_window_batch();
            // leave some transfers open across a window change
            if ($urandom_range(0, 1) == 0) send_item(OP_TIMEOUT, 6'($urandom_range(0, 63)));
            i_valid <= 1'b0;
            sender_quiet = 1'b0;
            sink_quiet = 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        $display("covered %0d requests over %0d window settings: %0d frames in window,",
                 sb.requests, sb.settings, sb.in_window_cnt);
        $display("%0d timeouts, %0d acknowledgements, %0d results checked",
                 sb.timeouts, sb.acks, sb.checked);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
